>>> design/lens_pkg.sv
// Shared constants, types and the saturating add for the lens distortion pipeline.
// Used by lens_distortion_map, lens_div, lens_mul and lens_dist_check; no dependencies.
`default_nettype none

package lens_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int COEF_WIDTH  = 24;
   localparam int NFRAC       = 24;
   localparam int CFRAC       = COEF_WIDTH - 4;
   localparam int OUT_WIDTH   = COORD_WIDTH + 4;
   localparam int CSR_WIDTH   = 2 * COORD_WIDTH;

   localparam int NUM_W       = COORD_WIDTH + NFRAC;
   localparam int DIV_STAGES  = NUM_W;

   localparam int MAG_W       = 61;
   localparam int VAL_W       = MAG_W + 2;
   localparam int LO_W        = (MAG_W + 1) / 2;
   localparam int HI_W        = MAG_W - LO_W;
   localparam int PROD_W      = 2 * MAG_W;
   localparam int MUL_STAGES  = 5;

   typedef logic signed [VAL_W-1:0] val_type;

   localparam val_type LIMIT     = {2'b00, {MAG_W{1'b1}}};
   localparam val_type NEG_LIMIT = -LIMIT;
   localparam val_type ONE_Q     = val_type'(64'd1 << NFRAC);

   typedef enum logic [2:0] {
      CSR_FOCAL_X,
      CSR_FOCAL_Y,
      CSR_PRINCIPAL,
      CSR_K1,
      CSR_K2,
      CSR_K3,
      CSR_P1,
      CSR_P2
   } csr_index_type;

   typedef struct packed {
      val_type val;
      logic    ovf;
   } sat_type;

   function automatic sat_type sat_add(input val_type a, input val_type b);
      val_type sum;
      sat_type res;
      sum = a + b;
      res.ovf = 1'b0;
      res.val = sum;
      if (sum > LIMIT) begin
         res.val = LIMIT;
         res.ovf = 1'b1;
      end else if (sum < NEG_LIMIT) begin
         res.val = NEG_LIMIT;
         res.ovf = 1'b1;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

>>> design/lens_div.sv
// Pipelined restoring divider: one quotient bit per stage, one request per cycle while en is high.
// Depends on lens_pkg for the dividend and divisor widths.
`default_nettype none

module lens_div (
   input  wire                              clock,
   input  wire                              en,
   input  wire  [lens_pkg::NUM_W-1:0]       num,
   input  wire  [lens_pkg::COORD_WIDTH-1:0] den,
   output logic [lens_pkg::NUM_W-1:0]       quo
);
   import lens_pkg::*;

   logic [COORD_WIDTH-1:0] rem_ff [1:DIV_STAGES];
   logic [COORD_WIDTH-1:0] rem_in [1:DIV_STAGES];
   logic [NUM_W-1:0]       nq_ff  [1:DIV_STAGES];
   logic [NUM_W-1:0]       nq_in  [1:DIV_STAGES];

   // nq shifts dividend bits out on the left and quotient bits in on the right
   always_comb begin
      logic [COORD_WIDTH-1:0] prev_rem;
      logic [NUM_W-1:0]       prev_nq;
      logic [COORD_WIDTH:0]   cand;
      logic [COORD_WIDTH:0]   diff;
      for (int k = 1; k <= DIV_STAGES; k++) begin
         prev_rem = (k == 1) ? '0 : rem_ff[k-1];
         prev_nq  = (k == 1) ? num : nq_ff[k-1];
         cand     = {prev_rem, prev_nq[NUM_W-1]};
         diff     = cand - {1'b0, den};
         if (cand >= {1'b0, den}) begin
            rem_in[k] = diff[COORD_WIDTH-1:0];
            nq_in[k]  = {prev_nq[NUM_W-2:0], 1'b1};
         end else begin
            rem_in[k] = cand[COORD_WIDTH-1:0];
            nq_in[k]  = {prev_nq[NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 1; k <= DIV_STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            nq_ff[k]  <= nq_in[k];
         end
      end
   end

   assign quo = nq_ff[DIV_STAGES];

endmodule

`default_nettype wire

>>> design/lens_mul.sv
// Five-stage signed multiply with rounded shift and saturation at +/-LIMIT.
// Depends on lens_pkg for widths, fraction bits and the value type.
`default_nettype none

module lens_mul (
   input  wire               clock,
   input  wire               en,
   input  lens_pkg::val_type a,
   input  lens_pkg::val_type b,
   input  wire               coef_sel,
   output lens_pkg::val_type prod,
   output logic              ovf
);
   import lens_pkg::*;

   localparam logic [PROD_W:0] RND_N = {{PROD_W{1'b0}}, 1'b1} << (NFRAC - 1);
   localparam logic [PROD_W:0] RND_C = {{PROD_W{1'b0}}, 1'b1} << (CFRAC - 1);

   val_type              a_abs, b_abs;
   logic [MAG_W-1:0]     ma1_ff, mb1_ff;
   logic                 neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic                 sel1_ff, sel2_ff, sel3_ff;
   logic [2*LO_W-1:0]    p00_ff;
   logic [LO_W+HI_W-1:0] p01_ff, p10_ff;
   logic [2*HI_W-1:0]    p11_ff;
   logic [PROD_W-1:0]    sum3_ff;
   logic [PROD_W:0]      rnd;
   logic [PROD_W:0]      sh4_ff;
   val_type              mag5;
   logic                 sat5;
   val_type              prod_ff;
   logic                 ovf_ff;

   always_comb begin
      a_abs = a[VAL_W-1] ? -a : a;
      b_abs = b[VAL_W-1] ? -b : b;
      rnd   = {1'b0, sum3_ff} + (sel3_ff ? RND_C : RND_N);
      sat5  = |sh4_ff[PROD_W:MAG_W];
      mag5  = sat5 ? LIMIT : {2'b00, sh4_ff[MAG_W-1:0]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // magnitudes and sign
         ma1_ff  <= a_abs[MAG_W-1:0];
         mb1_ff  <= b_abs[MAG_W-1:0];
         neg1_ff <= a[VAL_W-1] ^ b[VAL_W-1];
         sel1_ff <= coef_sel;
         // partial products
         p00_ff  <= ma1_ff[LO_W-1:0] * mb1_ff[LO_W-1:0];
         p01_ff  <= ma1_ff[LO_W-1:0] * mb1_ff[MAG_W-1:LO_W];
         p10_ff  <= ma1_ff[MAG_W-1:LO_W] * mb1_ff[LO_W-1:0];
         p11_ff  <= ma1_ff[MAG_W-1:LO_W] * mb1_ff[MAG_W-1:LO_W];
         neg2_ff <= neg1_ff;
         sel2_ff <= sel1_ff;
         // full product
         sum3_ff <= PROD_W'(p00_ff) + (PROD_W'(p01_ff) << LO_W)
                    + (PROD_W'(p10_ff) << LO_W) + (PROD_W'(p11_ff) << (2 * LO_W));
         neg3_ff <= neg2_ff;
         sel3_ff <= sel2_ff;
         // round half away from zero on the magnitude
         sh4_ff  <= sel3_ff ? (rnd >> CFRAC) : (rnd >> NFRAC);
         neg4_ff <= neg3_ff;
         // saturate, restore sign
         prod_ff <= neg4_ff ? -mag5 : mag5;
         ovf_ff  <= sat5;
      end
   end

   assign prod = prod_ff;
   assign ovf  = ovf_ff;

endmodule

`default_nettype wire

>>> design/lens_distortion_map.sv
// Top level of the Brown-Conrady lens distortion pipeline.
// Depends on lens_pkg, lens_div and lens_mul.
//
// Maps one undistorted pixel point (unsigned Q12.4) to its distorted position
// (signed Q15.4, saturated) per clock while the output is not held. Each
// request passes 78 register stages: one setup stage, a 40-stage divider that
// normalizes by the focal lengths, then chains of five-stage multipliers and
// single-stage saturating adds for r^2, r^4, r^6, the radial and tangential
// terms and the mapping back to pixels. The pipeline moves as one; it holds
// only while a finished result sits unread at the output, so req_ready follows
// rsp_ready whenever rsp_valid is high. rsp_clipped reports any saturation
// along the way or at the output range. Write the registers only while no
// request is in flight; csr_ready is always high.
`default_nettype none

module lens_distortion_map (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  [lens_pkg::COORD_WIDTH-1:0]   req_undist_x,
   input  wire  [lens_pkg::COORD_WIDTH-1:0]   req_undist_y,
   input  wire                                req_last_point,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic signed [lens_pkg::OUT_WIDTH-1:0] rsp_dist_x,
   output logic signed [lens_pkg::OUT_WIDTH-1:0] rsp_dist_y,
   output logic                               rsp_clipped,
   output logic                               rsp_last_out,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  lens_pkg::csr_index_type            csr_index,
   input  wire  [lens_pkg::CSR_WIDTH-1:0]     csr_data
);
   import lens_pkg::*;

   // stage positions, counted from the setup register
   localparam int S_X    = DIV_STAGES + 1;
   localparam int S_SQ   = S_X + MUL_STAGES;
   localparam int S_R2   = S_SQ + 1;
   localparam int S_T    = S_R2 + 1;
   localparam int S_P1   = S_T + MUL_STAGES;
   localparam int S_RAD1 = S_P1 + 1;
   localparam int S_P2   = S_P1 + MUL_STAGES;
   localparam int S_RAD2 = S_P2 + 1;
   localparam int S_P3   = S_P2 + MUL_STAGES;
   localparam int S_RAD3 = S_P3 + 1;
   localparam int S_XR   = S_RAD3 + MUL_STAGES;
   localparam int S_XD1  = S_XR + 1;
   localparam int S_XD   = S_XD1 + 1;
   localparam int S_PX   = S_XD + MUL_STAGES;
   localparam int S_OUT  = S_PX + 1;

   localparam int DLY_X    = S_RAD3 - S_X;
   localparam int DLY_R2   = S_P1 - S_T;
   localparam int DLY_RAD1 = S_P2 - S_RAD1;
   localparam int DLY_RAD2 = S_P3 - S_RAD2;
   localparam int DLY_A    = S_XR - S_P1;
   localparam int DLY_B    = S_XD1 - S_P1;

   localparam val_type OUT_MAX = val_type'((64'd1 << (OUT_WIDTH - 1)) - 64'd1);
   localparam val_type OUT_MIN = -OUT_MAX - val_type'(1);

   // configuration registers
   logic [COORD_WIDTH-1:0] focal_x_ff, focal_y_ff;
   logic [CSR_WIDTH-1:0]   principal_ff;
   logic [COEF_WIDTH-1:0]  k1_ff, k2_ff, k3_ff, p1_ff, p2_ff;

   logic [COORD_WIDTH-1:0] cx, cy, fxe, fye;
   val_type                k1e, k2e, k3e, p1e, p2e, fxv, fyv, cxv, cyv;

   logic                   en;

   // setup stage
   logic signed [COORD_WIDTH:0] dx, dy;
   logic [COORD_WIDTH:0]        adx, ady;
   logic [NUM_W-1:0]            numx_in, numy_in, numx_ff, numy_ff;
   logic                        negx0_ff, negy0_ff;
   logic [NUM_W-1:0]            quo_x, quo_y;
   logic                        negx_dl_ff [1:DIV_STAGES];
   logic                        negy_dl_ff [1:DIV_STAGES];

   // control travelling with the data
   logic                 v_ff    [0:S_OUT];
   logic                 last_ff [0:S_OUT];
   logic                 ovf_ff  [S_R2:S_OUT];
   logic [S_OUT:S_R2]    hit;

   val_type x_ff, y_ff;
   val_type xx_p, yy_p, xy_p;
   logic    xx_o, yy_o, xy_o;
   sat_type r2_s, xy2_s, xx2_s, yy2_s, tx_s, ty_s;
   val_type r2_ff, xy2_ff, xx2_ff, yy2_ff;
   val_type tx_ff, ty_ff, r2t_ff, xy2t_ff;
   val_type r4_p, k1r2_p, ax_p, bx_p, ay_p, by_p;
   logic    r4_o, k1r2_o, ax_o, bx_o, ay_o, by_o;
   sat_type rad1_s, rad2_s, rad3_s;
   val_type rad1_ff, rad2_ff, rad3_ff;
   val_type r6_p, k2r4_p, k3r6_p;
   logic    r6_o, k2r4_o, k3r6_o;
   val_type xr_p, yr_p;
   logic    xr_o, yr_o;
   sat_type xd1_s, yd1_s, xd_s, yd_s;
   val_type xd1_ff, yd1_ff, xd_ff, yd_ff;
   val_type px_p, py_p;
   logic    px_o, py_o;

   val_type x_dl_ff    [1:DLY_X];
   val_type y_dl_ff    [1:DLY_X];
   val_type r2_dl_ff   [1:DLY_R2];
   val_type rad1_dl_ff [1:DLY_RAD1];
   val_type rad2_dl_ff [1:DLY_RAD2];
   val_type ax_dl_ff   [1:DLY_A];
   val_type ay_dl_ff   [1:DLY_A];
   val_type bx_dl_ff   [1:DLY_B];
   val_type by_dl_ff   [1:DLY_B];

   // output stage
   val_type                      pxc, pyc;
   logic                         clip_x, clip_y;
   logic signed [OUT_WIDTH-1:0]  dist_x_in, dist_y_in, dist_x_ff, dist_y_ff;

   // ---------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff   <= COORD_WIDTH'(16000);
         focal_y_ff   <= COORD_WIDTH'(16000);
         principal_ff <= '0;
         k1_ff        <= '0;
         k2_ff        <= '0;
         k3_ff        <= '0;
         p1_ff        <= '0;
         p2_ff        <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FOCAL_X:   focal_x_ff   <= csr_data[COORD_WIDTH-1:0];
            CSR_FOCAL_Y:   focal_y_ff   <= csr_data[COORD_WIDTH-1:0];
            CSR_PRINCIPAL: principal_ff <= csr_data;
            CSR_K1:        k1_ff        <= csr_data[COEF_WIDTH-1:0];
            CSR_K2:        k2_ff        <= csr_data[COEF_WIDTH-1:0];
            CSR_K3:        k3_ff        <= csr_data[COEF_WIDTH-1:0];
            CSR_P1:        p1_ff        <= csr_data[COEF_WIDTH-1:0];
            CSR_P2:        p2_ff        <= csr_data[COEF_WIDTH-1:0];
         endcase
      end
   end

   // a zero focal length acts as one LSB
   always_comb begin
      cx  = principal_ff[COORD_WIDTH-1:0];
      cy  = principal_ff[CSR_WIDTH-1:COORD_WIDTH];
      fxe = (focal_x_ff == '0) ? COORD_WIDTH'(1) : focal_x_ff;
      fye = (focal_y_ff == '0) ? COORD_WIDTH'(1) : focal_y_ff;
      k1e = {{(VAL_W-COEF_WIDTH){k1_ff[COEF_WIDTH-1]}}, k1_ff};
      k2e = {{(VAL_W-COEF_WIDTH){k2_ff[COEF_WIDTH-1]}}, k2_ff};
      k3e = {{(VAL_W-COEF_WIDTH){k3_ff[COEF_WIDTH-1]}}, k3_ff};
      p1e = {{(VAL_W-COEF_WIDTH){p1_ff[COEF_WIDTH-1]}}, p1_ff};
      p2e = {{(VAL_W-COEF_WIDTH){p2_ff[COEF_WIDTH-1]}}, p2_ff};
      fxv = {{(VAL_W-COORD_WIDTH){1'b0}}, fxe};
      fyv = {{(VAL_W-COORD_WIDTH){1'b0}}, fye};
      cxv = {{(VAL_W-COORD_WIDTH){1'b0}}, cx};
      cyv = {{(VAL_W-COORD_WIDTH){1'b0}}, cy};
   end

   // ---------------------------------------------------------------------
   // Flow control: advance everything unless a result is held at the output
   // ---------------------------------------------------------------------
   assign en        = !v_ff[S_OUT] || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= S_OUT; i++) v_ff[i] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= req_valid;
         for (int i = 1; i <= S_OUT; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         last_ff[0] <= req_last_point;
         for (int i = 1; i <= S_OUT; i++) last_ff[i] <= last_ff[i-1];
         // sticky overflow flag, fed where each unit finishes
         ovf_ff[S_R2] <= hit[S_R2];
         for (int i = S_R2 + 1; i <= S_OUT; i++) ovf_ff[i] <= ovf_ff[i-1] | hit[i];
      end
   end

   // ---------------------------------------------------------------------
   // Setup: offset from the principal point, dividend for normalization
   // ---------------------------------------------------------------------
   always_comb begin
      dx      = $signed({1'b0, req_undist_x}) - $signed({1'b0, cx});
      dy      = $signed({1'b0, req_undist_y}) - $signed({1'b0, cy});
      adx     = dx[COORD_WIDTH] ? -dx : dx;
      ady     = dy[COORD_WIDTH] ? -dy : dy;
      numx_in = {adx[COORD_WIDTH-1:0], {NFRAC{1'b0}}} + NUM_W'(fxe >> 1);
      numy_in = {ady[COORD_WIDTH-1:0], {NFRAC{1'b0}}} + NUM_W'(fye >> 1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         numx_ff  <= numx_in;
         numy_ff  <= numy_in;
         negx0_ff <= dx[COORD_WIDTH];
         negy0_ff <= dy[COORD_WIDTH];
         negx_dl_ff[1] <= negx0_ff;
         negy_dl_ff[1] <= negy0_ff;
         for (int i = 2; i <= DIV_STAGES; i++) begin
            negx_dl_ff[i] <= negx_dl_ff[i-1];
            negy_dl_ff[i] <= negy_dl_ff[i-1];
         end
      end
   end

   lens_div u_div_x (.clock(clock), .en(en), .num(numx_ff), .den(fxe), .quo(quo_x));
   lens_div u_div_y (.clock(clock), .en(en), .num(numy_ff), .den(fye), .quo(quo_y));

   // ---------------------------------------------------------------------
   // Normalized point, squares and cross term
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= negx_dl_ff[DIV_STAGES] ? -val_type'({{(VAL_W-NUM_W){1'b0}}, quo_x})
                                        :  val_type'({{(VAL_W-NUM_W){1'b0}}, quo_x});
         y_ff <= negy_dl_ff[DIV_STAGES] ? -val_type'({{(VAL_W-NUM_W){1'b0}}, quo_y})
                                        :  val_type'({{(VAL_W-NUM_W){1'b0}}, quo_y});
      end
   end

   lens_mul u_mul_xx (.clock(clock), .en(en), .a(x_ff), .b(x_ff), .coef_sel(1'b0),
                      .prod(xx_p), .ovf(xx_o));
   lens_mul u_mul_yy (.clock(clock), .en(en), .a(y_ff), .b(y_ff), .coef_sel(1'b0),
                      .prod(yy_p), .ovf(yy_o));
   lens_mul u_mul_xy (.clock(clock), .en(en), .a(x_ff), .b(y_ff), .coef_sel(1'b0),
                      .prod(xy_p), .ovf(xy_o));

   // saturating adds, each feeding one register stage
   always_comb begin
      r2_s   = sat_add(xx_p, yy_p);
      xy2_s  = sat_add(xy_p, xy_p);
      xx2_s  = sat_add(xx_p, xx_p);
      yy2_s  = sat_add(yy_p, yy_p);
      tx_s   = sat_add(r2_ff, xx2_ff);
      ty_s   = sat_add(r2_ff, yy2_ff);
      rad1_s = sat_add(ONE_Q, k1r2_p);
      rad2_s = sat_add(rad1_dl_ff[DLY_RAD1], k2r4_p);
      rad3_s = sat_add(rad2_dl_ff[DLY_RAD2], k3r6_p);
      xd1_s  = sat_add(xr_p, ax_dl_ff[DLY_A]);
      yd1_s  = sat_add(yr_p, ay_dl_ff[DLY_A]);
      xd_s   = sat_add(xd1_ff, bx_dl_ff[DLY_B]);
      yd_s   = sat_add(yd1_ff, by_dl_ff[DLY_B]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r2_ff   <= r2_s.val;
         xy2_ff  <= xy2_s.val;
         xx2_ff  <= xx2_s.val;
         yy2_ff  <= yy2_s.val;
         tx_ff   <= tx_s.val;
         ty_ff   <= ty_s.val;
         r2t_ff  <= r2_ff;
         xy2t_ff <= xy2_ff;
         rad1_ff <= rad1_s.val;
         rad2_ff <= rad2_s.val;
         rad3_ff <= rad3_s.val;
         xd1_ff  <= xd1_s.val;
         yd1_ff  <= yd1_s.val;
         xd_ff   <= xd_s.val;
         yd_ff   <= yd_s.val;
      end
   end

   // ---------------------------------------------------------------------
   // r^4, first radial term and all tangential products
   // ---------------------------------------------------------------------
   lens_mul u_mul_r4   (.clock(clock), .en(en), .a(r2t_ff), .b(r2t_ff), .coef_sel(1'b0),
                        .prod(r4_p), .ovf(r4_o));
   lens_mul u_mul_k1   (.clock(clock), .en(en), .a(k1e), .b(r2t_ff), .coef_sel(1'b1),
                        .prod(k1r2_p), .ovf(k1r2_o));
   lens_mul u_mul_ax   (.clock(clock), .en(en), .a(p1e), .b(xy2t_ff), .coef_sel(1'b1),
                        .prod(ax_p), .ovf(ax_o));
   lens_mul u_mul_bx   (.clock(clock), .en(en), .a(p2e), .b(tx_ff), .coef_sel(1'b1),
                        .prod(bx_p), .ovf(bx_o));
   lens_mul u_mul_ay   (.clock(clock), .en(en), .a(p2e), .b(xy2t_ff), .coef_sel(1'b1),
                        .prod(ay_p), .ovf(ay_o));
   lens_mul u_mul_by   (.clock(clock), .en(en), .a(p1e), .b(ty_ff), .coef_sel(1'b1),
                        .prod(by_p), .ovf(by_o));

   // r^6 and the second and third radial terms
   lens_mul u_mul_r6   (.clock(clock), .en(en), .a(r4_p), .b(r2_dl_ff[DLY_R2]),
                        .coef_sel(1'b0), .prod(r6_p), .ovf(r6_o));
   lens_mul u_mul_k2   (.clock(clock), .en(en), .a(k2e), .b(r4_p), .coef_sel(1'b1),
                        .prod(k2r4_p), .ovf(k2r4_o));
   lens_mul u_mul_k3   (.clock(clock), .en(en), .a(k3e), .b(r6_p), .coef_sel(1'b1),
                        .prod(k3r6_p), .ovf(k3r6_o));

   // radial scale of the point
   lens_mul u_mul_xr   (.clock(clock), .en(en), .a(x_dl_ff[DLY_X]), .b(rad3_ff),
                        .coef_sel(1'b0), .prod(xr_p), .ovf(xr_o));
   lens_mul u_mul_yr   (.clock(clock), .en(en), .a(y_dl_ff[DLY_X]), .b(rad3_ff),
                        .coef_sel(1'b0), .prod(yr_p), .ovf(yr_o));

   // back to pixels
   lens_mul u_mul_px   (.clock(clock), .en(en), .a(xd_ff), .b(fxv), .coef_sel(1'b0),
                        .prod(px_p), .ovf(px_o));
   lens_mul u_mul_py   (.clock(clock), .en(en), .a(yd_ff), .b(fyv), .coef_sel(1'b0),
                        .prod(py_p), .ovf(py_o));

   // hold operands until their partner arrives
   always_ff @(posedge clock) begin
      if (en) begin
         x_dl_ff[1]    <= x_ff;
         y_dl_ff[1]    <= y_ff;
         r2_dl_ff[1]   <= r2t_ff;
         rad1_dl_ff[1] <= rad1_ff;
         rad2_dl_ff[1] <= rad2_ff;
         ax_dl_ff[1]   <= ax_p;
         ay_dl_ff[1]   <= ay_p;
         bx_dl_ff[1]   <= bx_p;
         by_dl_ff[1]   <= by_p;
         for (int i = 2; i <= DLY_X; i++) begin
            x_dl_ff[i] <= x_dl_ff[i-1];
            y_dl_ff[i] <= y_dl_ff[i-1];
         end
         for (int i = 2; i <= DLY_R2; i++) r2_dl_ff[i] <= r2_dl_ff[i-1];
         for (int i = 2; i <= DLY_RAD1; i++) rad1_dl_ff[i] <= rad1_dl_ff[i-1];
         for (int i = 2; i <= DLY_RAD2; i++) rad2_dl_ff[i] <= rad2_dl_ff[i-1];
         for (int i = 2; i <= DLY_A; i++) begin
            ax_dl_ff[i] <= ax_dl_ff[i-1];
            ay_dl_ff[i] <= ay_dl_ff[i-1];
         end
         for (int i = 2; i <= DLY_B; i++) begin
            bx_dl_ff[i] <= bx_dl_ff[i-1];
            by_dl_ff[i] <= by_dl_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output: add the center, clamp to the result range
   // ---------------------------------------------------------------------
   always_comb begin
      pxc    = px_p + cxv;
      pyc    = py_p + cyv;
      clip_x = (pxc > OUT_MAX) || (pxc < OUT_MIN);
      clip_y = (pyc > OUT_MAX) || (pyc < OUT_MIN);
      priority if (pxc > OUT_MAX) dist_x_in = OUT_MAX[OUT_WIDTH-1:0];
      else if (pxc < OUT_MIN)     dist_x_in = OUT_MIN[OUT_WIDTH-1:0];
      else                        dist_x_in = pxc[OUT_WIDTH-1:0];
      priority if (pyc > OUT_MAX) dist_y_in = OUT_MAX[OUT_WIDTH-1:0];
      else if (pyc < OUT_MIN)     dist_y_in = OUT_MIN[OUT_WIDTH-1:0];
      else                        dist_y_in = pyc[OUT_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_x_ff <= dist_x_in;
         dist_y_ff <= dist_y_in;
      end
   end

   // overflow sources, placed at the stage their result enters
   always_comb begin
      hit         = '0;
      hit[S_R2]   = xx_o | yy_o | xy_o | r2_s.ovf | xy2_s.ovf | xx2_s.ovf | yy2_s.ovf;
      hit[S_T]    = tx_s.ovf | ty_s.ovf;
      hit[S_RAD1] = r4_o | k1r2_o | ax_o | bx_o | ay_o | by_o | rad1_s.ovf;
      hit[S_RAD2] = r6_o | k2r4_o | rad2_s.ovf;
      hit[S_RAD3] = k3r6_o | rad3_s.ovf;
      hit[S_XD1]  = xr_o | yr_o | xd1_s.ovf | yd1_s.ovf;
      hit[S_XD]   = xd_s.ovf | yd_s.ovf;
      hit[S_OUT]  = px_o | py_o | clip_x | clip_y;
   end

   assign rsp_valid    = v_ff[S_OUT];
   assign rsp_dist_x   = dist_x_ff;
   assign rsp_dist_y   = dist_y_ff;
   assign rsp_clipped  = ovf_ff[S_OUT];
   assign rsp_last_out = last_ff[S_OUT];

endmodule

`default_nettype wire

>>> design/lens_dist_check.sv
// Port-level checks for lens_distortion_map, attached by the bind at the end.
// Depends on lens_pkg for port widths.
`default_nettype none

module lens_dist_check (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_ready,
   input wire                                rsp_valid,
   input wire                                rsp_ready,
   input wire [lens_pkg::OUT_WIDTH-1:0]      rsp_dist_x,
   input wire [lens_pkg::OUT_WIDTH-1:0]      rsp_dist_y,
   input wire                                rsp_clipped,
   input wire                                rsp_last_out
);

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // the pipeline only holds while a result waits at the output
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request refused with output free");

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dist_x) && $stable(rsp_dist_y)
      && $stable(rsp_clipped) && $stable(rsp_last_out))
      else $error("held result changed");

endmodule

bind lens_distortion_map lens_dist_check u_lens_dist_check (.*);

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for lens_distortion_map (Brown-Conrady point distortion).
// Depends on lens_pkg and the lens_distortion_map RTL; predicts each request in fixed point.
`timescale 1ns / 1ps

module tb_top;
   import lens_pkg::*;

   localparam longint SAT_LIM = (64'sd1 <<< 61) - 1;
   localparam int     FLUSH_CYCLES = 100;

   typedef struct {
      logic [15:0] ux;
      logic [15:0] uy;
      logic        last;
   } point_type;

   typedef struct {
      logic signed [19:0] dx;
      logic signed [19:0] dy;
      logic               clip;
      logic               last;
   } dist_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [15:0]         req_undist_x = '0;
   logic [15:0]         req_undist_y = '0;
   logic                req_last_point = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic signed [19:0]  rsp_dist_x;
   logic signed [19:0]  rsp_dist_y;
   logic                rsp_clipped;
   logic                rsp_last_out;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   csr_index_type       csr_index = CSR_FOCAL_X;
   logic [31:0]         csr_data = '0;

   lens_distortion_map DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_undist_x(req_undist_x), .req_undist_y(req_undist_y),
      .req_last_point(req_last_point),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_dist_x(rsp_dist_x), .rsp_dist_y(rsp_dist_y),
      .rsp_clipped(rsp_clipped), .rsp_last_out(rsp_last_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the lens registers, updated on each accepted write.
   logic [15:0] focal_x_q = 16'd16000;
   logic [15:0] focal_y_q = 16'd16000;
   logic [31:0] center_q  = '0;
   logic [23:0] k1_q = '0, k2_q = '0, k3_q = '0, p1_q = '0, p2_q = '0;

   point_type pending_points[$];
   dist_type  expected_points[$];
   int     error_cnt = 0;
   int     send_idle_pct = 0;
   int     recv_idle_pct = 0;
   int     stall_asked = 0;
   int     stall_served = 0;
   int     hold_left = 0;
   logic   req_took = 1'b0;

   // round(a*b / 2^s), half away from zero, saturated at the intermediate limit
   function automatic longint mul_round(longint a, longint b, int s, inout bit ovf);
      bit           neg;
      logic [127:0] ma, mb, prod;
      longint       r;
      neg  = (a < 0) != (b < 0);
      ma   = (a < 0) ? -a : a;
      mb   = (b < 0) ? -b : b;
      prod = ((ma * mb) + (128'd1 << (s - 1))) >> s;
      if (prod > SAT_LIM) begin
         ovf = 1'b1;
         r = SAT_LIM;
      end else begin
         r = prod[63:0];
      end
      return neg ? -r : r;
   endfunction

   function automatic longint add_sat(longint a, longint b, inout bit ovf);
      longint sum;
      sum = a + b;
      if (sum > SAT_LIM) begin
         ovf = 1'b1;
         return SAT_LIM;
      end
      if (sum < -SAT_LIM) begin
         ovf = 1'b1;
         return -SAT_LIM;
      end
      return sum;
   endfunction

   function automatic longint norm_coord(logic [15:0] u, logic [15:0] c, logic [15:0] f);
      longint d, md, fl;
      d  = longint'(u) - longint'(c);
      md = (d < 0) ? -d : d;
      fl = (f == 0) ? 1 : longint'(f);
      md = ((md <<< NFRAC) + (fl >>> 1)) / fl;
      return (d < 0) ? -md : md;
   endfunction

   function automatic logic [19:0] back_to_pixel(longint nd, logic [15:0] f, logic [15:0] c,
                                                 inout bit ovf);
      longint p, fl;
      fl = (f == 0) ? 1 : longint'(f);
      p  = mul_round(nd, fl, NFRAC, ovf) + longint'(c);
      if (p > 524287) begin
         ovf = 1'b1;
         p = 524287;
      end
      if (p < -524288) begin
         ovf = 1'b1;
         p = -524288;
      end
      return p[19:0];
   endfunction

   function automatic dist_type distort_point(point_type pt);
      bit       ovf;
      longint   k1, k2, k3, p1, p2, x, y, xx, yy, xy, r2, r4, r6, xy2, rad, xd, yd;
      dist_type res;
      ovf = 1'b0;
      k1 = longint'($signed(k1_q));
      k2 = longint'($signed(k2_q));
      k3 = longint'($signed(k3_q));
      p1 = longint'($signed(p1_q));
      p2 = longint'($signed(p2_q));
      x   = norm_coord(pt.ux, center_q[15:0], focal_x_q);
      y   = norm_coord(pt.uy, center_q[31:16], focal_y_q);
      xx  = mul_round(x, x, NFRAC, ovf);
      yy  = mul_round(y, y, NFRAC, ovf);
      xy  = mul_round(x, y, NFRAC, ovf);
      r2  = add_sat(xx, yy, ovf);
      r4  = mul_round(r2, r2, NFRAC, ovf);
      r6  = mul_round(r4, r2, NFRAC, ovf);
      xy2 = add_sat(xy, xy, ovf);
      rad = longint'(1) <<< NFRAC;
      rad = add_sat(rad, mul_round(k1, r2, CFRAC, ovf), ovf);
      rad = add_sat(rad, mul_round(k2, r4, CFRAC, ovf), ovf);
      rad = add_sat(rad, mul_round(k3, r6, CFRAC, ovf), ovf);
      xd = mul_round(x, rad, NFRAC, ovf);
      xd = add_sat(xd, mul_round(p1, xy2, CFRAC, ovf), ovf);
      xd = add_sat(xd, mul_round(p2, add_sat(r2, add_sat(xx, xx, ovf), ovf), CFRAC, ovf),
                   ovf);
      yd = mul_round(y, rad, NFRAC, ovf);
      yd = add_sat(yd, mul_round(p2, xy2, CFRAC, ovf), ovf);
      yd = add_sat(yd, mul_round(p1, add_sat(r2, add_sat(yy, yy, ovf), ovf), CFRAC, ovf),
                   ovf);
      res.dx   = back_to_pixel(xd, focal_x_q, center_q[15:0], ovf);
      res.dy   = back_to_pixel(yd, focal_y_q, center_q[31:16], ovf);
      res.clip = ovf;
      res.last = pt.last;
      return res;
   endfunction

   // Request side: predict and pop on acceptance at the rising edge.
   always @(posedge clock) begin
      req_took <= req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         expected_points.insert(expected_points.size(), distort_point(pending_points[0]));
         pending_points.pop_front();
      end
   end

   // Drive the next request at the falling edge; hold it until accepted.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid      <= 1'b1;
            req_undist_x   <= pending_points[0].ux;
            req_undist_y   <= pending_points[0].uy;
            req_last_point <= pending_points[0].last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side backpressure; a long hold-off lets the pipeline fill and stall input.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_asked != stall_served) begin
         stall_served++;
         hold_left = 400;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each delivered result with the oldest prediction.
   always @(posedge clock) begin
      dist_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            $error("unexpected result dist_x=%0d dist_y=%0d", rsp_dist_x, rsp_dist_y);
            error_cnt++;
         end else begin
            want = expected_points.pop_front();
            if (rsp_dist_x !== want.dx) begin
               $error("dist_x expected %0d got %0d", want.dx, rsp_dist_x);
               error_cnt++;
            end
            if (rsp_dist_y !== want.dy) begin
               $error("dist_y expected %0d got %0d", want.dy, rsp_dist_y);
               error_cnt++;
            end
            if (rsp_clipped !== want.clip) begin
               $error("clipped expected %0b got %0b", want.clip, rsp_clipped);
               error_cnt++;
            end
            if (rsp_last_out !== want.last) begin
               $error("last_out expected %0b got %0b", want.last, rsp_last_out);
               error_cnt++;
            end
         end
      end
   end

   task automatic write_reg(csr_index_type idx, logic [31:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FOCAL_X:   focal_x_q = data[15:0];
         CSR_FOCAL_Y:   focal_y_q = data[15:0];
         CSR_PRINCIPAL: center_q  = data;
         CSR_K1:        k1_q = data[23:0];
         CSR_K2:        k2_q = data[23:0];
         CSR_K3:        k3_q = data[23:0];
         CSR_P1:        p1_q = data[23:0];
         CSR_P2:        p2_q = data[23:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic load_lens(logic [15:0] fx, logic [15:0] fy, logic [31:0] pp,
                            int k1, int k2, int k3, int p1, int p2);
      write_reg(CSR_FOCAL_X, {16'd0, fx});
      write_reg(CSR_FOCAL_Y, {16'd0, fy});
      write_reg(CSR_PRINCIPAL, pp);
      write_reg(CSR_K1, k1);
      write_reg(CSR_K2, k2);
      write_reg(CSR_K3, k3);
      write_reg(CSR_P1, p1);
      write_reg(CSR_P2, p2);
   endtask

   // Wait until every request has been answered, then let the pipeline flush.
   task automatic drain();
      while (pending_points.size() > 0 || expected_points.size() > 0) @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);
   endtask

   task automatic add_point(logic [15:0] ux, logic [15:0] uy, logic last);
      point_type pt;
      pt.ux = ux;
      pt.uy = uy;
      pt.last = last;
      pending_points.insert(pending_points.size(), pt);
   endtask

   // Mostly points near the optical center, some anywhere in range.
   task automatic add_random_points(int n);
      logic [15:0] ux, uy;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(3) == 0) begin
            ux = 16'($urandom);
            uy = 16'($urandom);
         end else begin
            ux = center_q[15:0] + 16'($signed($urandom_range(16000)) - 8000);
            uy = center_q[31:16] + 16'($signed($urandom_range(16000)) - 8000);
         end
         add_point(ux, uy, $urandom_range(7) == 0);
      end
   endtask

   // Random signed coefficient in Q3.20, uniform in -span..span.
   function automatic int soft_coef(int span);
      return $signed($urandom_range(2 * span)) - span;
   endfunction

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset registers: identity mapping, corners and edges of the pixel grid.
      add_point(16'h0000, 16'h0000, 1'b0);
      add_point(16'hFFFF, 16'hFFFF, 1'b1);
      add_point(16'h0000, 16'hFFFF, 1'b0);
      add_point(16'hFFFF, 16'h0000, 1'b1);
      add_point(16'h8000, 16'h7FFF, 1'b0);
      add_point(16'h5555, 16'hAAAA, 1'b0);
      drain();

      // Zero focal length and extreme coefficients: intermediate overflow and clipping.
      load_lens(16'd0, 16'd16, 32'h8000_8000, 8388607, -8388608, 8388607,
                -8388608, 8388607);
      add_point(16'h8000, 16'h8000, 1'b0);
      add_point(16'h8001, 16'h8000, 1'b0);
      add_point(16'h0000, 16'h0000, 1'b1);
      add_point(16'hFFFF, 16'hFFFF, 1'b0);
      add_point(16'h8000, 16'h8010, 1'b1);
      drain();
      load_lens(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, -8388608, 8388607, -8388608,
                8388607, -8388608);
      add_point(16'h0000, 16'h0000, 1'b0);
      add_point(16'hFFFF, 16'hFFFF, 1'b1);
      add_point(16'h0000, 16'hFFFF, 1'b0);
      add_point(16'h7FFF, 16'h8000, 1'b1);
      drain();
      // Small focal lengths with mild distortion: output range clamping.
      load_lens(16'd16, 16'd16, 32'h0000_0000, 1000, 0, 0, 0, 0);
      add_point(16'h0010, 16'h0010, 1'b0);
      add_point(16'h0100, 16'h0000, 1'b0);
      add_point(16'hFFFF, 16'h0020, 1'b1);
      drain();

      // Random phases: sender sparse idling with a slow receiver.
      send_idle_pct = 13;
      recv_idle_pct = 77;
      load_lens(16'd16000, 16'd15000, {16'd8640, 16'd15360}, soft_coef(300000),
                soft_coef(100000), soft_coef(30000), soft_coef(5000), soft_coef(5000));
      add_random_points(320);
      drain();

      // Swap the idling and force one long hold-off so the input stalls.
      send_idle_pct = 77;
      recv_idle_pct = 13;
      load_lens(16'($urandom_range(65535, 2000)), 16'($urandom_range(65535, 2000)),
                $urandom, soft_coef(1000000), soft_coef(1000000), soft_coef(500000),
                soft_coef(200000), soft_coef(200000));
      add_random_points(100);
      while (pending_points.size() > 0) @(posedge clock);
      send_idle_pct = 0;
      stall_asked++;
      add_random_points(200);
      drain();

      // No idling: full-range random registers, then a moderate lens.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_lens(16'($urandom), 16'($urandom), $urandom, soft_coef(8388607),
                soft_coef(8388607), soft_coef(8388607), soft_coef(8388607),
                soft_coef(8388607));
      add_random_points(150);
      drain();
      load_lens(16'd20000, 16'd20000, {16'd8000, 16'd12000}, soft_coef(200000),
                soft_coef(50000), soft_coef(10000), soft_coef(3000), soft_coef(3000));
      add_random_points(150);
      drain();

      if (error_cnt == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
